// ===== rtl/sme_pkg.sv =====
`default_nettype none
package sme_pkg;
	localparam int unsigned STACK_DEPTH_D = 128;
	localparam int unsigned CODE_SIZE_D   = 1024;
	localparam int unsigned FRAC_BITS_D   = 16;
	localparam int unsigned PC_W          = 10;

	localparam logic [4:0] OP_HALT = 5'd0;
	localparam logic [4:0] OP_ADD  = 5'd1;
	localparam logic [4:0] OP_SUB  = 5'd2;
	localparam logic [4:0] OP_MUL  = 5'd3;
	localparam logic [4:0] OP_DIVR = 5'd4;
	localparam logic [4:0] OP_DIVI = 5'd5;
	localparam logic [4:0] OP_NEG  = 5'd6;
	localparam logic [4:0] OP_AND  = 5'd7;
	localparam logic [4:0] OP_OR   = 5'd8;
	localparam logic [4:0] OP_NOT  = 5'd9;
	localparam logic [4:0] OP_EQ   = 5'd10;
	localparam logic [4:0] OP_LT   = 5'd11;
	localparam logic [4:0] OP_GT   = 5'd12;
	localparam logic [4:0] OP_SPUP = 5'd13;
	localparam logic [4:0] OP_SPDN = 5'd14;
	localparam logic [4:0] OP_PUSH = 5'd15;
	localparam logic [4:0] OP_STOR = 5'd17;
	localparam logic [4:0] OP_LOAD = 5'd18;
	localparam logic [4:0] OP_JMP  = 5'd19;
	localparam logic [4:0] OP_JF   = 5'd20;
	localparam logic [4:0] OP_IN   = 5'd21;
	localparam logic [4:0] OP_OUT  = 5'd22;

	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_OVF  = 3'd1;
	localparam logic [2:0] ST_UNF  = 3'd2;
	localparam logic [2:0] ST_DIV0 = 3'd3;
	localparam logic [2:0] ST_UNSUP = 3'd4;
	localparam logic [2:0] ST_BADA = 3'd5;

	// divider request / reply
	typedef struct packed {
		logic        start;
		logic [63:0] num;  // magnitude
		logic [31:0] den;  // magnitude
	} div_req_t;
	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/sme_div.sv =====
`default_nettype none
// unsigned 64/32 restoring divider, one quotient bit per cycle
module sme_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sme_pkg::div_req_t req,
	output sme_pkg::div_rsp_t     rsp
);
	import sme_pkg::*;
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so 32 bits hold it
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
	assign rsp = '{done: done_q, quo: quo_q};
endmodule
`default_nettype wire

// ===== rtl/stack_machine_execute.sv =====
`default_nettype none
// Sequence: after the accepting edge an item passes RD1 (read top), RD2 (read second)
//   and EXE (execute, result registered); load adds RD3 (indirect read), divides add
//   DIV to wait for the bit-serial divider; halt, and every item once halted, answer
//   at the accepting edge itself.
// Flow: one item at a time, the next one accepted once the result has been taken.
// Reset: sp = -1, pc = 0, halt clear; stack memory contents undefined until written.
module stack_machine_execute #(
	parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_D,
	parameter int unsigned CODE_SIZE   = sme_pkg::CODE_SIZE_D,
	parameter int unsigned FRAC_BITS   = sme_pkg::FRAC_BITS_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [4:0] opcode, [36:5] operand, [68:37] read_value, rest zero
	input  wire logic [71:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [9:0] next_pc, [41:10] out_value, [42] out_valid, [43] halted, [46:44] status
	output logic [47:0]      m_tdata
);
	import sme_pkg::*;

	localparam int unsigned AW  = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = AW + 2;   // signed stack pointer, room for -1 and depth
	localparam int unsigned CW  = $clog2(CODE_SIZE);
	localparam logic signed [63:0] QMAX = 64'sd2147483647;
	localparam logic signed [63:0] QMIN = -64'sd2147483648;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD1  = 6'b000010,
		S_RD2  = 6'b000100,
		S_RD3  = 6'b001000,
		S_EXE  = 6'b010000,
		S_DIV  = 6'b100000
	} state_t;

	state_t state_q;
	logic [4:0]  op_q;
	logic signed [31:0] opnd_q, rv_q;
	logic signed [31:0] top_q, sec_q;
	logic signed [SPW-1:0] sp_q;
	logic [CW-1:0] pc_q;
	logic halt_q;

	// stack memory, one write and one registered read port
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [31:0] wr_data;
	logic wr_en;
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// integer part, truncated toward zero
	function automatic logic signed [31:0] ipart(input logic signed [31:0] v);
		logic signed [31:0] f;
		f = v >>> FRAC_BITS;
		if (v < 0 && (v & ((32'sd1 <<< FRAC_BITS) - 32'sd1)) != 0) f = f + 32'sd1;
		return f;
	endfunction
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > QMAX) return 32'h7FFF_FFFF;
		if (v < QMIN) return 32'h8000_0000;
		return v[31:0];
	endfunction

	logic signed [SPW-1:0] sp1;
	assign sp1 = sp_q - SPW'(1);

	logic in_acc, out_acc;
	assign s_tready = (state_q == S_IDLE) && !m_tvalid;
	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;

	// read address per phase
	logic signed [31:0] idx_top;
	assign idx_top = ipart(top_q);
	always_comb begin
		rd_addr = sp_q[AW-1:0];
		if (state_q == S_RD1) rd_addr = sp1[AW-1:0];
		else if (state_q == S_RD2) rd_addr = idx_top[AW-1:0];
	end

	// divider
	div_req_t dreq;
	div_rsp_t drsp;
	sme_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	logic neg_q;

	// execute
	logic signed [63:0] prod, r64, a64, b64;
	logic signed [31:0] ia, ib;
	logic [2:0] st;
	logic ovf, upd, outv_en, need_div;
	logic signed [SPW-1:0] nsp;
	logic [CW:0] npc;
	logic signed [32:0] dsp;
	logic [63:0] dnum;
	logic [31:0] dden;
	logic dneg;

	assign a64 = 64'(sec_q);
	assign b64 = 64'(top_q);
	assign ia  = ipart(sec_q);
	assign ib  = ipart(top_q);
	assign prod = a64 * b64;

	always_comb begin
		st = ST_OK; ovf = 1'b0; upd = 1'b0; outv_en = 1'b0; need_div = 1'b0;
		nsp = sp_q; npc = {1'b0, pc_q}; r64 = '0;
		wr_en = 1'b0; wr_addr = sp_q[AW-1:0]; wr_data = '0;
		dsp = '0; dnum = '0; dden = '0; dneg = 1'b0;
		case (op_q)
			OP_ADD, OP_SUB, OP_MUL, OP_DIVR, OP_DIVI, OP_AND, OP_OR, OP_EQ, OP_LT,
			OP_GT: begin
				if (sp_q < SPW'(1)) st = ST_UNF;
				else begin
					case (op_q)
						OP_ADD: r64 = a64 + b64;
						OP_SUB: r64 = a64 - b64;
						OP_MUL: r64 = prod >>> FRAC_BITS;
						OP_AND: r64 = 64'(ia & ib) <<< FRAC_BITS;
						OP_OR:  r64 = 64'(ia | ib) <<< FRAC_BITS;
						OP_EQ:  r64 = (a64 == b64) ? (64'sd1 <<< FRAC_BITS) : '0;
						OP_LT:  r64 = (a64 < b64) ? (64'sd1 <<< FRAC_BITS) : '0;
						default: r64 = (a64 > b64) ? (64'sd1 <<< FRAC_BITS) : '0;
					endcase
					if (op_q == OP_DIVR) begin
						if (top_q == 0) st = ST_DIV0;
						else begin
							need_div = 1'b1;
							dnum = sec_q[31] ? 64'(-a64) << FRAC_BITS : 64'(a64) << FRAC_BITS;
							dden = top_q[31] ? 32'(-b64) : top_q;
							dneg = sec_q[31] ^ top_q[31];
						end
					end else if (op_q == OP_DIVI) begin
						if (ib == 0) st = ST_DIV0;
						else begin
							need_div = 1'b1;
							dnum = ia[31] ? 64'(-64'(ia)) : 64'(ia);
							dden = ib[31] ? 32'(-ib) : ib;
							dneg = ia[31] ^ ib[31];
						end
					end else begin
						ovf = (r64 > QMAX) || (r64 < QMIN);
						wr_en = 1'b1; wr_addr = sp1[AW-1:0]; wr_data = sat32(r64);
						nsp = sp1; npc = npc + 1'b1; upd = 1'b1;
					end
				end
			end
			OP_NEG, OP_NOT: begin
				if (sp_q[SPW-1]) st = ST_UNF;
				else begin
					r64 = (op_q == OP_NEG) ? -b64 : (64'sd1 - 64'(ib)) <<< FRAC_BITS;
					ovf = (r64 > QMAX) || (r64 < QMIN);
					wr_en = 1'b1; wr_data = sat32(r64);
					npc = npc + 1'b1; upd = 1'b1;
				end
			end
			OP_SPUP, OP_SPDN: begin
				dsp = (op_q == OP_SPUP) ? 33'(sp_q) + 33'(opnd_q) : 33'(sp_q) - 33'(opnd_q);
				if (dsp > $signed(33'(STACK_DEPTH - 1))) st = ST_OVF;
				else if (dsp < -33'sd1) st = ST_UNF;
				else begin nsp = SPW'(dsp); npc = npc + 2'd2; upd = 1'b1; end
			end
			OP_PUSH: begin
				if (sp_q + SPW'(1) > SPW'(STACK_DEPTH - 1)) st = ST_OVF;
				else begin
					r64 = 64'(opnd_q) <<< FRAC_BITS;
					ovf = (r64 > QMAX) || (r64 < QMIN);
					nsp = sp_q + SPW'(1);
					wr_en = 1'b1; wr_addr = nsp[AW-1:0]; wr_data = sat32(r64);
					npc = npc + 2'd2; upd = 1'b1;
				end
			end
			OP_STOR: begin
				if (sp_q < SPW'(1)) st = ST_UNF;
				else if (ia < 0 || ia >= 32'(STACK_DEPTH)) st = ST_BADA;
				else begin
					wr_en = 1'b1; wr_addr = ia[AW-1:0]; wr_data = top_q;
					nsp = sp_q - SPW'(2); npc = npc + 1'b1; upd = 1'b1;
				end
			end
			OP_LOAD: begin
				if (sp_q[SPW-1]) st = ST_UNF;
				else if (ib < 0 || ib >= 32'(STACK_DEPTH)) st = ST_BADA;
				else begin
					wr_en = 1'b1; wr_data = sec_q;  // sec holds indirect read
					npc = npc + 1'b1; upd = 1'b1;
				end
			end
			OP_JMP: begin
				if (opnd_q < 0 || opnd_q >= 32'(CODE_SIZE)) st = ST_BADA;
				else begin npc = (CW+1)'(opnd_q); upd = 1'b1; end
			end
			OP_JF: begin
				if (sp_q[SPW-1]) st = ST_UNF;
				else if (top_q == 0) begin
					if (opnd_q < 0 || opnd_q >= 32'(CODE_SIZE)) st = ST_BADA;
					else begin npc = (CW+1)'(opnd_q); nsp = sp1; upd = 1'b1; end
				end else begin npc = npc + 2'd2; nsp = sp1; upd = 1'b1; end
			end
			OP_IN: begin
				if (sp_q[SPW-1]) st = ST_UNF;
				else if (ib < 0 || ib >= 32'(STACK_DEPTH)) st = ST_BADA;
				else begin
					wr_en = 1'b1; wr_addr = ib[AW-1:0]; wr_data = rv_q;
					nsp = sp1; npc = npc + 1'b1; upd = 1'b1;
				end
			end
			OP_OUT: begin
				if (sp_q[SPW-1]) st = ST_UNF;
				else begin outv_en = 1'b1; nsp = sp1; npc = npc + 1'b1; upd = 1'b1; end
			end
			default: st = ST_UNSUP;
		endcase
		if (st == ST_OK && ovf) st = ST_OVF;
		// writes only in execute or divider write-back, only for an instruction that commits
		if (state_q != S_EXE || need_div) wr_en = 1'b0;
		// divider write-back
		if (state_q == S_DIV) begin
			r64 = neg_q ? -$signed(drsp.quo) : $signed(drsp.quo);
			if (op_q == OP_DIVI) r64 = r64 <<< FRAC_BITS;
			ovf = (r64 > QMAX) || (r64 < QMIN)
				|| (!neg_q && drsp.quo[63]) || (op_q == OP_DIVI && drsp.quo[63:31] != '0);
			if (op_q == OP_DIVI && drsp.quo[63:31] != '0)
				r64 = neg_q ? QMIN : QMAX;
			wr_en = drsp.done; wr_addr = sp1[AW-1:0]; wr_data = sat32(r64);
			if (ovf) wr_data = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
			if (r64 >= QMIN && r64 <= QMAX && !ovf) wr_data = r64[31:0];
			st = ovf ? ST_OVF : ST_OK;
			nsp = sp1; npc = {1'b0, pc_q} + 1'b1; upd = 1'b1;
		end
	end

	assign dreq.start = (state_q == S_EXE) && need_div;
	assign dreq.num   = dnum;
	assign dreq.den   = dden;

	logic [CW-1:0] npc_w;
	assign npc_w = npc[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sp_q     <= '1;
			pc_q     <= '0;
			halt_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (out_acc) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (halt_q) begin
							m_tvalid <= 1'b1;
							m_tdata  <= {1'b0, ST_OK, 1'b1, 1'b0, 32'd0, PC_W'(pc_q)};
						end else if (s_tdata[4:0] == OP_HALT) begin
							halt_q   <= 1'b1;
							m_tvalid <= 1'b1;
							m_tdata  <= {1'b0, ST_OK, 1'b1, 1'b0, 32'd0, PC_W'(pc_q)};
						end else state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= (op_q == OP_LOAD) ? S_RD3 : S_EXE;
				S_RD3: state_q <= S_EXE;
				S_EXE: begin
					if (need_div) state_q <= S_DIV;
					else begin
						state_q  <= S_IDLE;
						if (upd) begin sp_q <= nsp; pc_q <= npc_w; end
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, st, 1'b0, outv_en, outv_en ? top_q : 32'd0,
							PC_W'(upd ? npc_w : pc_q)};
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						state_q  <= S_IDLE;
						sp_q     <= nsp;
						pc_q     <= npc_w;
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, st, 1'b0, 1'b0, 32'd0, PC_W'(npc_w)};
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers: capture item, top, second operand or load's indirect read, divide sign
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= s_tdata[4:0];
			opnd_q <= s_tdata[36:5];
			rv_q   <= s_tdata[68:37];
		end
		if (state_q == S_RD1) top_q <= sp_q[SPW-1] ? 32'd0 : rd_q;
		if (state_q == S_RD2) sec_q <= rd_q;
		if (state_q == S_RD3) sec_q <= rd_q;
		if (dreq.start) neg_q <= dneg;
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE)) else $error("ready outside idle");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt flag cleared");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q >= -SPW'(1)) && (sp_q <= $signed(SPW'(STACK_DEPTH - 1))))
		else $error("stack pointer out of range");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == S_DIV)) else $error("divider done outside wait");
`endif
endmodule
`default_nettype wire

// ===== test/tb_stack_machine_execute.sv =====
`default_nettype none
module tb_stack_machine_execute;
	timeunit 1ns;
	timeprecision 1ps;
	import sme_pkg::*;

	localparam int DEPTH = 128;
	localparam int CODE = 1024;
	localparam longint QONE = 64'sd65536;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam logic [4:0] OP_BAD16 = 5'd16;
	localparam logic [4:0] OP_BAD31 = 5'd31;
	localparam int N_RANDOM = 820;
	localparam int CYCLE_LIMIT = 1000000;

	// one executed instruction as seen on the result bus, lowest field last
	typedef struct packed {
		logic [2:0]  st;
		logic        hl;
		logic        ov;
		logic [31:0] outv;
		logic [9:0]  pc;
	} res_t;

	// directed stimulus row; typed rows carry a hand-written pc and status
	typedef struct {
		logic [4:0]  op;
		logic [31:0] opnd;
		logic [31:0] rv;
		bit          typed;
		logic [9:0]  pc;
		logic [2:0]  st;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [4:0] opcode, [36:5] operand, [68:37] read_value, rest zero
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [9:0] next_pc, [41:10] out_value, [42] out_valid, [43] halted, [46:44] status
	logic [47:0] m_tdata;

	// machine state mirrored by the predictor
	logic signed [31:0] mem_q [DEPTH];
	bit                 wr_q [DEPTH];
	int                 sp_q;
	int                 pc_q;
	bit                 halt_q;

	res_t pending_results[$];
	int   phase = 0;      // 0: sender idles 32%, receiver 51%; 1: swapped; 2: no idling
	int   errors = 0;
	int   n_items = 0;
	int   n_results = 0;
	int   n_outputs = 0;
	int   n_faults = 0;
	int   cycles = 0;

	stack_machine_execute DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic longint ipart(longint q);
		return q / QONE;   // truncates toward zero
	endfunction

	function automatic logic [31:0] sat32(longint v, inout bit ovf);
		if (v > QMAX) begin
			ovf = 1'b1;
			return QMAX[31:0];
		end
		if (v < QMIN) begin
			ovf = 1'b1;
			return QMIN[31:0];
		end
		return v[31:0];
	endfunction

	function automatic bit is_binop(logic [4:0] op);
		return op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIVR, OP_DIVI, OP_AND, OP_OR,
			OP_EQ, OP_LT, OP_GT};
	endfunction

	// true when executing op now would read a stack entry never written
	function automatic bit reads_blank(logic [4:0] op);
		longint d;
		if (halt_q)
			return 1'b0;
		if ((is_binop(op) || op == OP_STOR) && sp_q >= 1)
			return !wr_q[sp_q] || !wr_q[sp_q - 1];
		if (op inside {OP_NEG, OP_NOT, OP_JF, OP_IN, OP_OUT, OP_LOAD} && sp_q >= 0) begin
			if (!wr_q[sp_q])
				return 1'b1;
			if (op == OP_LOAD) begin
				d = ipart(longint'(mem_q[sp_q]));
				return d >= 0 && d < DEPTH && !wr_q[d];
			end
		end
		return 1'b0;
	endfunction

	// executes one instruction on the mirrored state, returns the expected result
	function automatic res_t exec_step(logic [4:0] op, logic signed [31:0] opnd,
			logic signed [31:0] rv);
		res_t   r;
		longint a, b, v, d, top;
		bit     ovf;
		logic [2:0] st;
		int     nsp, npc;
		r = '0;
		st = ST_OK;
		ovf = 1'b0;
		nsp = sp_q;
		npc = pc_q;
		v = 0;
		top = (sp_q >= 0) ? longint'(mem_q[sp_q]) : 0;
		if (!halt_q) begin
			if (op == OP_HALT) begin
				halt_q = 1'b1;
			end else if (is_binop(op)) begin
				if (sp_q < 1) begin
					st = ST_UNF;
				end else begin
					a = longint'(mem_q[sp_q - 1]);
					b = top;
					case (op)
						OP_ADD: v = a + b;
						OP_SUB: v = a - b;
						OP_MUL: v = (a * b) >>> 16;   // floor
						OP_DIVR: begin
							if (b == 0) st = ST_DIV0;
							else v = (a * QONE) / b;
						end
						OP_DIVI: begin
							if (ipart(b) == 0) st = ST_DIV0;
							else v = (ipart(a) / ipart(b)) * QONE;
						end
						OP_AND: v = (ipart(a) & ipart(b)) * QONE;
						OP_OR:  v = (ipart(a) | ipart(b)) * QONE;
						OP_EQ:  v = (a == b) ? QONE : 0;
						OP_LT:  v = (a < b) ? QONE : 0;
						default: v = (a > b) ? QONE : 0;
					endcase
					if (st == ST_OK) begin
						mem_q[sp_q - 1] = sat32(v, ovf);
						nsp = sp_q - 1;
						npc = pc_q + 1;
					end
				end
			end else begin
				case (op)
					OP_NEG, OP_NOT: begin
						if (sp_q < 0) begin
							st = ST_UNF;
						end else begin
							v = (op == OP_NEG) ? -top : (1 - ipart(top)) * QONE;
							mem_q[sp_q] = sat32(v, ovf);
							npc = pc_q + 1;
						end
					end
					OP_SPUP, OP_SPDN: begin
						d = (op == OP_SPUP) ? longint'(sp_q) + longint'(opnd)
							: longint'(sp_q) - longint'(opnd);
						if (d > DEPTH - 1) st = ST_OVF;
						else if (d < -1) st = ST_UNF;
						else begin
							nsp = int'(d);
							npc = pc_q + 2;
						end
					end
					OP_PUSH: begin
						if (sp_q + 1 > DEPTH - 1) begin
							st = ST_OVF;
						end else begin
							nsp = sp_q + 1;
							mem_q[nsp] = sat32(longint'(opnd) * QONE, ovf);
							wr_q[nsp] = 1'b1;
							npc = pc_q + 2;
						end
					end
					OP_STOR: begin
						if (sp_q < 1) st = ST_UNF;
						else begin
							d = ipart(longint'(mem_q[sp_q - 1]));
							if (d < 0 || d >= DEPTH) st = ST_BADA;
							else begin
								mem_q[d] = top[31:0];
								wr_q[d] = 1'b1;
								nsp = sp_q - 2;
								npc = pc_q + 1;
							end
						end
					end
					OP_LOAD: begin
						if (sp_q < 0) st = ST_UNF;
						else begin
							d = ipart(top);
							if (d < 0 || d >= DEPTH) st = ST_BADA;
							else begin
								mem_q[sp_q] = mem_q[d];
								npc = pc_q + 1;
							end
						end
					end
					OP_JMP: begin
						if (opnd < 0 || opnd >= CODE) st = ST_BADA;
						else npc = int'(opnd);
					end
					OP_JF: begin
						if (sp_q < 0) st = ST_UNF;
						else begin
							if (top == 0) begin
								if (opnd < 0 || opnd >= CODE) st = ST_BADA;
								else npc = int'(opnd);
							end else begin
								npc = pc_q + 2;
							end
							if (st == ST_OK) nsp = sp_q - 1;
						end
					end
					OP_IN: begin
						if (sp_q < 0) st = ST_UNF;
						else begin
							d = ipart(top);
							if (d < 0 || d >= DEPTH) st = ST_BADA;
							else begin
								mem_q[d] = rv;
								wr_q[d] = 1'b1;
								nsp = sp_q - 1;
								npc = pc_q + 1;
							end
						end
					end
					OP_OUT: begin
						if (sp_q < 0) st = ST_UNF;
						else begin
							r.outv = top[31:0];
							r.ov = 1'b1;
							nsp = sp_q - 1;
							npc = pc_q + 1;
						end
					end
					default: st = ST_UNSUP;
				endcase
			end
			if (st == ST_OK && ovf)
				st = ST_OVF;
			sp_q = nsp;
			pc_q = npc % CODE;
		end
		r.pc = pc_q[9:0];
		r.hl = halt_q;
		r.st = st;
		return r;
	endfunction

	// drives one item, honoring the sender idle rate of the current phase
	task automatic send_item(logic [4:0] op, logic [31:0] opnd, logic [31:0] rv,
			bit typed, logic [9:0] tpc, logic [2:0] tst);
		int   idle_pct;
		res_t r;
		idle_pct = (phase == 0) ? 32 : ((phase == 1) ? 51 : 0);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, rv, opnd, op};
		do @(posedge clk); while (!s_tready);
		r = exec_step(op, opnd, rv);
		if (typed) begin
			r = '0;
			r.pc = tpc;
			r.st = tst;
		end
		pending_results.push_back(r);
		n_items++;
	endtask

	// random instruction shaped as a program: pushes keep the stack fed,
	// operands mostly small integers, addresses and in-range jump targets
	task automatic gen_item(output logic [4:0] op, output logic [31:0] opnd,
			output logic [31:0] rv);
		int k;
		logic [4:0] ops [21] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIVR, OP_DIVI, OP_NEG,
			OP_AND, OP_OR, OP_NOT, OP_EQ, OP_LT, OP_GT, OP_SPUP, OP_SPDN, OP_PUSH,
			OP_STOR, OP_LOAD, OP_JMP, OP_JF, OP_IN, OP_OUT};
		k = $urandom_range(0, 99);
		rv = $urandom;
		if (k < 5) begin
			op = 5'($urandom_range(0, 31));   // noise, unsupported codes among them
			if (op == OP_HALT) op = OP_BAD16;
			opnd = $urandom;
		end else if (k < 40 || (sp_q < 2 && k < 70)) begin
			op = OP_PUSH;
		end else begin
			op = ops[$urandom_range(0, 20)];
		end
		if (k >= 5) begin
			k = $urandom_range(0, 99);
			case (op)
				OP_JMP, OP_JF: opnd = (k < 85) ? $urandom_range(0, CODE - 1) : $urandom;
				OP_SPUP, OP_SPDN: begin
					if (k < 85) opnd = $urandom_range(0, 3);
					else if (k < 95) opnd = $urandom_range(0, 200);
					else opnd = $urandom;
				end
				default: begin
					if (k < 45) opnd = $urandom_range(0, 2 * DEPTH) - 8;
					else if (k < 85) opnd = $urandom_range(0, 80) - 40;
					else opnd = $urandom;
				end
			endcase
		end
		if (reads_blank(op)) begin
			op = OP_PUSH;
			opnd = $urandom_range(0, DEPTH - 1);
		end
	endtask

	// receiver stall pattern follows the phase
	always @(posedge clk) begin
		if (phase == 2)
			m_tready <= 1'b1;
		else
			m_tready <= $urandom_range(0, 99) >= ((phase == 0) ? 51 : 32);
	end

	// result checker: field by field against the oldest expectation
	always @(posedge clk) begin
		res_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[46:0];
			n_results++;
			if (pending_results.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.ov) n_outputs++;
				if (got.st != ST_OK) n_faults++;
				if (got.pc !== want.pc) begin
					$error("next_pc expected %0d got %0d", want.pc, got.pc);
					errors++;
				end
				if (got.outv !== want.outv) begin
					$error("out_value expected %h got %h", want.outv, got.outv);
					errors++;
				end
				if (got.ov !== want.ov) begin
					$error("out_valid expected %b got %b", want.ov, got.ov);
					errors++;
				end
				if (got.hl !== want.hl) begin
					$error("halted expected %b got %b", want.hl, got.hl);
					errors++;
				end
				if (got.st !== want.st) begin
					$error("status expected %0d got %0d", want.st, got.st);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		row_t       tab [$];
		logic [4:0]  op;
		logic [31:0] opnd, rv;
		// error paths on an empty stack, saturation, divide by zero,
		// then most other operations on known data
		tab = '{
			'{OP_ADD,   0,          0, 1, 10'd0, ST_UNF},
			'{OP_BAD16, 32'hFFFFFFFF, 0, 1, 10'd0, ST_UNSUP},
			'{OP_BAD31, 0,          0, 1, 10'd0, ST_UNSUP},
			'{OP_JMP,   -1,         0, 1, 10'd0, ST_BADA},
			'{OP_SPUP,  200,        0, 1, 10'd0, ST_OVF},
			'{OP_SPDN,  1,          0, 1, 10'd0, ST_UNF},
			'{OP_PUSH,  32767,      0, 1, 10'd2, ST_OK},
			'{OP_PUSH,  32768,      0, 1, 10'd4, ST_OVF},
			'{OP_ADD,   0,          0, 1, 10'd5, ST_OVF},
			'{OP_PUSH,  0,          0, 1, 10'd7, ST_OK},
			'{OP_DIVR,  0,          0, 1, 10'd7, ST_DIV0},
			'{OP_DIVI,  0,          0, 1, 10'd7, ST_DIV0},
			'{OP_SUB,   0,          0, 0, 0, 0},
			'{OP_NEG,   0,          0, 0, 0, 0},
			'{OP_PUSH,  -32768,     0, 0, 0, 0},
			'{OP_MUL,   0,          0, 0, 0, 0},
			'{OP_PUSH,  3,          0, 0, 0, 0},
			'{OP_DIVR,  0,          0, 0, 0, 0},
			'{OP_NOT,   0,          0, 0, 0, 0},
			'{OP_PUSH,  2,          0, 0, 0, 0},
			'{OP_OR,    0,          0, 0, 0, 0},
			'{OP_PUSH,  -5,         0, 0, 0, 0},
			'{OP_AND,   0,          0, 0, 0, 0},
			'{OP_PUSH,  4,          0, 0, 0, 0},
			'{OP_EQ,    0,          0, 0, 0, 0},
			'{OP_PUSH,  1,          0, 0, 0, 0},
			'{OP_LT,    0,          0, 0, 0, 0},
			'{OP_PUSH,  1,          0, 0, 0, 0},
			'{OP_GT,    0,          0, 0, 0, 0},
			'{OP_PUSH,  7,          0, 0, 0, 0},
			'{OP_STOR,  0,          0, 0, 0, 0},
			'{OP_PUSH,  1,          0, 0, 0, 0},
			'{OP_IN,    0, 32'h80000000, 0, 0, 0},
			'{OP_PUSH,  1,          0, 0, 0, 0},
			'{OP_LOAD,  0,          0, 0, 0, 0},
			'{OP_OUT,   0,          0, 0, 0, 0},
			'{OP_PUSH,  0,          0, 0, 0, 0},
			'{OP_JF,    1023,       0, 0, 0, 0},
			'{OP_JMP,   1023,       0, 0, 0, 0},
			'{OP_PUSH,  1,          0, 0, 0, 0},
			'{OP_SPDN,  2,          0, 0, 0, 0}
		};
		foreach (mem_q[i]) begin
			mem_q[i] = '0;
			wr_q[i] = 1'b0;
		end
		sp_q = -1;
		pc_q = 0;
		halt_q = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tab[i])
			send_item(tab[i].op, tab[i].opnd, tab[i].rv, tab[i].typed, tab[i].pc, tab[i].st);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) phase = 1;
			if (n == 2 * N_RANDOM / 3) phase = 2;
			// hold off once until the block has drained
			if (n == N_RANDOM / 2) begin
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			gen_item(op, opnd, rv);
			send_item(op, opnd, rv, 1'b0, '0, '0);
		end

		// halt last, since nothing but reset leaves that state
		send_item(OP_HALT, $urandom, $urandom, 1'b0, '0, '0);
		repeat (4) begin
			gen_item(op, opnd, rv);
			send_item(op, opnd, rv, 1'b0, '0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("%0d instructions executed, %0d results checked: %0d outputs, %0d faults,",
			n_items, n_results, n_outputs, n_faults);
		$display("across three stall patterns, a drain pause and a final halt");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
